// ===== src/zmbr_pkg.sv =====
// Shared types, constants and codes for the branch unit.
package zmbr_pkg;

    localparam int ADDR_BITS = 19;
    localparam int PC_BITS   = 19;
    localparam int MEM_BITS  = 20;
    localparam int TGT_BITS  = 21;
    localparam int OPND_BITS = 16;

    localparam logic [32:0] ADDR_LIMIT = 33'd1 << ADDR_BITS;
    localparam logic [PC_BITS-1:0] PC_MASK = (ADDR_BITS >= PC_BITS) ? '1
        : PC_BITS'(ADDR_LIMIT - 33'd1);

    localparam logic [MEM_BITS-1:0] MEM_BYTES_RESET = 20'h80000;

    localparam logic [7:0]  SENSE_BIT  = 8'h80;
    localparam logic [7:0]  OFFSET_LOW = 8'h3f;
    localparam logic [7:0]  SHORT_BIT  = 8'h40;
    localparam logic [15:0] LONG_SIGN  = 16'h2000;
    localparam logic [15:0] LONG_EXT   = 16'hc000;

    localparam logic [2:0] KIND_JZ   = 3'd0;
    localparam logic [2:0] KIND_JE   = 3'd1;
    localparam logic [2:0] KIND_JL   = 3'd2;
    localparam logic [2:0] KIND_JG   = 3'd3;
    localparam logic [2:0] KIND_JUMP = 3'd4;

    localparam logic [2:0] ARGC_ONE   = 3'd1;
    localparam logic [2:0] ARGC_TWO   = 3'd2;
    localparam logic [2:0] ARGC_THREE = 3'd3;

    localparam logic [1:0] ACT_FALL   = 2'd0;
    localparam logic [1:0] ACT_TAKEN  = 2'd1;
    localparam logic [1:0] ACT_RFALSE = 2'd2;
    localparam logic [1:0] ACT_RTRUE  = 2'd3;

    typedef struct packed {
        logic [2:0]           kind;
        logic [2:0]           arg_count;
        logic [OPND_BITS-1:0] first_operand;
        logic [OPND_BITS-1:0] second_operand;
        logic [OPND_BITS-1:0] third_operand;
        logic [OPND_BITS-1:0] fourth_operand;
        logic [PC_BITS-1:0]   current_pc;
        logic [7:0]           branch_byte_a;
        logic [7:0]           branch_byte_b;
    } req_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [PC_BITS-1:0] next_pc;
        logic               bad_target;
    } rsp_t;

endpackage

// ===== src/zmbr_in_if.sv =====
// Request channel carrying one branch instruction.
interface zmbr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  arg_count;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic [15:0] third_operand;
    logic [15:0] fourth_operand;
    logic [18:0] current_pc;
    logic [7:0]  branch_byte_a;
    logic [7:0]  branch_byte_b;

    modport source (
        output valid, kind, arg_count, first_operand, second_operand,
               third_operand, fourth_operand, current_pc, branch_byte_a, branch_byte_b,
        input  ready
    );

    modport sink (
        input  valid, kind, arg_count, first_operand, second_operand,
               third_operand, fourth_operand, current_pc, branch_byte_a, branch_byte_b,
        output ready
    );
endinterface

// ===== src/zmbr_out_if.sv =====
// Result channel carrying one branch outcome.
interface zmbr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [18:0] next_pc;
    logic        bad_target;

    modport source (
        output valid, action, next_pc, bad_target,
        input  ready
    );

    modport sink (
        input  valid, action, next_pc, bad_target,
        output ready
    );
endinterface

// ===== src/zmachine_branch_unit.sv =====
// Branch unit top level: input register, evaluation, result register.
// A request is held in the input register, then in the result register (two register stages).
// Throughput: one instruction per cycle while the result register is not stalled;
// between the registers lie the condition test, offset decode, 21-bit target add, compare.
// Both stages advance together whenever the result register is empty or drained.
// Reset empties both stages and sets the memory size to 524288 bytes.
module zmachine_branch_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [zmbr_pkg::MEM_BITS-1:0] cfg_wdata,
    zmbr_in_if.sink                       req,
    zmbr_out_if.source                    rsp
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    zmbr_pkg::req_t                s1_data_reg;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    zmbr_pkg::rsp_t                s2_data_reg;
    zmbr_pkg::rsp_t                eval_rsp;
    logic [zmbr_pkg::MEM_BITS-1:0] mem_bytes_reg;
    logic                          advance;
    logic                          req_xfer;

    assign advance  = !s2_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    assign s1_valid_next = req_xfer || (s1_valid_reg && !advance);
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            mem_bytes_reg <= zmbr_pkg::MEM_BYTES_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (cfg_we)
            begin
                mem_bytes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_data_reg.kind           <= req.kind;
            s1_data_reg.arg_count      <= req.arg_count;
            s1_data_reg.first_operand  <= req.first_operand;
            s1_data_reg.second_operand <= req.second_operand;
            s1_data_reg.third_operand  <= req.third_operand;
            s1_data_reg.fourth_operand <= req.fourth_operand;
            s1_data_reg.current_pc     <= req.current_pc;
            s1_data_reg.branch_byte_a  <= req.branch_byte_a;
            s1_data_reg.branch_byte_b  <= req.branch_byte_b;
        end
        if (advance && s1_valid_reg)
        begin
            s2_data_reg <= eval_rsp;
        end
    end

    zmbr_eval u_eval
    (
        .req          (s1_data_reg),
        .memory_bytes (mem_bytes_reg),
        .rsp          (eval_rsp)
    );

    assign rsp.valid      = s2_valid_reg;
    assign rsp.action     = s2_data_reg.action;
    assign rsp.next_pc    = s2_data_reg.next_pc;
    assign rsp.bad_target = s2_data_reg.bad_target;

`ifndef SYNTH
    a_bad_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bad_target |-> rsp.action == zmbr_pkg::ACT_TAKEN)
        else $error("bad_target set on a result that is not taken");

    a_return_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.action == zmbr_pkg::ACT_RFALSE || rsp.action == zmbr_pkg::ACT_RTRUE)
        |-> rsp.next_pc == '0)
        else $error("return result carries a nonzero next_pc");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("stalled input stage lost its instruction");

    a_xfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> s1_valid_reg)
        else $error("transferred request did not reach the input stage");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> s2_valid_reg)
        else $error("advancing instruction did not reach the result stage");
`endif

endmodule

// ===== src/zmbr_eval.sv =====
// Condition test, offset decode and target computation for one instruction.
module zmbr_eval
(
    input  zmbr_pkg::req_t               req,
    input  logic [zmbr_pkg::MEM_BITS-1:0] memory_bytes,
    output zmbr_pkg::rsp_t               rsp
);

    logic                             cond;
    logic                             known;
    logic [7:0]                       ba_eff;
    logic                             short_form;
    logic [15:0]                      off;
    logic [zmbr_pkg::MEM_BITS-1:0]    after;
    logic [zmbr_pkg::MEM_BITS-1:0]    base;
    logic [15:0]                      offs;
    logic [zmbr_pkg::TGT_BITS-1:0]    tgt;
    logic                             bad;
    logic                             is_jump;

    always_comb
    begin
        cond  = 1'b0;
        known = 1'b1;
        case (req.kind)
            zmbr_pkg::KIND_JZ:
            begin
                cond = (req.first_operand == 16'd0);
            end
            zmbr_pkg::KIND_JE:
            begin
                case (req.arg_count)
                    zmbr_pkg::ARGC_ONE:   cond = 1'b0;
                    zmbr_pkg::ARGC_TWO:   cond = (req.first_operand == req.second_operand);
                    zmbr_pkg::ARGC_THREE: cond = (req.first_operand == req.second_operand)
                                              || (req.first_operand == req.third_operand);
                    default:              cond = (req.first_operand == req.second_operand)
                                              || (req.first_operand == req.third_operand)
                                              || (req.first_operand == req.fourth_operand);
                endcase
            end
            zmbr_pkg::KIND_JL:
            begin
                cond = ($signed(req.first_operand) < $signed(req.second_operand));
            end
            zmbr_pkg::KIND_JG:
            begin
                cond = ($signed(req.first_operand) > $signed(req.second_operand));
            end
            zmbr_pkg::KIND_JUMP:
            begin
                cond = 1'b1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign is_jump    = (req.kind == zmbr_pkg::KIND_JUMP);
    assign ba_eff     = cond ? req.branch_byte_a : (req.branch_byte_a ^ zmbr_pkg::SENSE_BIT);
    assign short_form = |(ba_eff & zmbr_pkg::SHORT_BIT);

    always_comb
    begin
        if (short_form)
        begin
            off   = {8'd0, ba_eff & zmbr_pkg::OFFSET_LOW};
            after = {1'b0, req.current_pc} + 20'd1;
        end
        else
        begin
            off   = {2'b00, ba_eff[5:0], req.branch_byte_b};
            if (|(off & zmbr_pkg::LONG_SIGN))
            begin
                off = off | zmbr_pkg::LONG_EXT;
            end
            after = {1'b0, req.current_pc} + 20'd2;
        end
    end

    assign base = is_jump ? {1'b0, req.current_pc} : after;
    assign offs = is_jump ? req.first_operand : off;
    assign tgt  = {1'b0, base}
                + {{(zmbr_pkg::TGT_BITS-16){offs[15]}}, offs}
                - zmbr_pkg::TGT_BITS'(2);

    assign bad = tgt[zmbr_pkg::TGT_BITS-1]
              || (tgt[zmbr_pkg::MEM_BITS-1:0] >= memory_bytes)
              || (33'(tgt[zmbr_pkg::TGT_BITS-2:0]) >= zmbr_pkg::ADDR_LIMIT);

    always_comb
    begin
        if (!known)
        begin
            rsp.action     = zmbr_pkg::ACT_FALL;
            rsp.next_pc    = req.current_pc;
            rsp.bad_target = 1'b0;
        end
        else if (!is_jump && !(|(ba_eff & zmbr_pkg::SENSE_BIT)))
        begin
            rsp.action     = zmbr_pkg::ACT_FALL;
            rsp.next_pc    = after[zmbr_pkg::PC_BITS-1:0] & zmbr_pkg::PC_MASK;
            rsp.bad_target = 1'b0;
        end
        else if (is_jump || (off > 16'd1))
        begin
            rsp.action     = zmbr_pkg::ACT_TAKEN;
            rsp.next_pc    = tgt[zmbr_pkg::PC_BITS-1:0] & zmbr_pkg::PC_MASK;
            rsp.bad_target = bad;
        end
        else if (off[0])
        begin
            rsp.action     = zmbr_pkg::ACT_RTRUE;
            rsp.next_pc    = '0;
            rsp.bad_target = 1'b0;
        end
        else
        begin
            rsp.action     = zmbr_pkg::ACT_RFALSE;
            rsp.next_pc    = '0;
            rsp.bad_target = 1'b0;
        end
    end

endmodule
